// ----- rtl/mwg_pkg.sv -----
// mwg_pkg: shared types, codes and constants of the waveform generator.
// No dependencies; the phase accumulator, sine table, shaper and top level import it.
package mwg_pkg;

  // Defaults for the top-level parameters
  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int AMP_BITS       = 15;
  localparam int ENTRY_BITS     = 15;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  // pi/2 in Q30, used to build the quarter-wave table
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Waveform select codes
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SINE_ALT = 2'd3
  } wave_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WAVE_KIND    = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_PHASE_STEP   = 3'd2,
    REG_PHASE_OFFSET = 3'd3,
    REG_START_PHASE  = 3'd4
  } cfg_reg_t;

  // Control that travels with a request down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// ----- rtl/mwg_if.sv -----
// Handshake channels of the waveform generator: request in, sample out.
// Depends on nothing; the sample width follows the SAMPLE_BITS parameter.
interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic final_sample;

  modport source (output valid, output restart, output final_sample, input ready);
  modport sink   (input valid, input restart, input final_sample, output ready);
endinterface

interface mwg_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ----- rtl/mwg_phase_acc.sv -----
// mwg_phase_acc: phase accumulator with restart, and the offset phase of each request.
// Depends on mwg_pkg.
module mwg_phase_acc #(
  parameter int PHASE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic                   restart,
  input  logic                   final_sample,
  input  logic [PHASE_BITS-1:0]  start_phase,
  input  logic [PHASE_BITS-1:0]  phase_step,
  input  logic [PHASE_BITS-1:0]  phase_offset,
  output mwg_pkg::stage_ctl_t    s1_ctl,
  output logic [PHASE_BITS-1:0]  s1_phase
);
  import mwg_pkg::*;

  logic [PHASE_BITS-1:0] acc;
  logic [PHASE_BITS-1:0] acc_cur;
  logic                  accept;

  assign accept  = in_valid && adv;
  // restart reloads the accumulator before this sample is formed
  assign acc_cur = restart ? start_phase : acc;

  // accumulator update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= acc_cur + phase_step;
    end
  end

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_ctl.valid <= in_valid;
      end
      if (accept) begin
        s1_ctl.last <= final_sample;
        s1_phase    <= acc_cur + phase_offset;
      end
    end
  end

endmodule

// ----- rtl/mwg_sine_rom.sv -----
// mwg_sine_rom: quarter-wave sine table with a synchronous, registered read.
// Depends on mwg_pkg; contents are built at elaboration from a Q30 Taylor series.
module mwg_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [TABLE_BITS-1:0]              addr,
  output logic [mwg_pkg::ENTRY_BITS-1:0]     data
);
  import mwg_pkg::*;

  localparam int TABLE_SIZE = 1 << TABLE_BITS;

  typedef logic [ENTRY_BITS-1:0] rom_t [TABLE_SIZE];

  // denominators (2n)(2n+1) of the series terms
  function automatic longint unsigned taylor_den(input int n);
    longint unsigned d;
    case (n)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      default: d = 64'd156;
    endcase
    return d;
  endfunction

  // truncating long division, only evaluated while the table is built
  function automatic longint unsigned div_const(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // entry k = sin(pi/2 * k / N) in Q15, clamped to 32767
  function automatic rom_t build_rom();
    rom_t            t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = div_const(term * x2, taylor_den(n));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd16384) >> 15;
      t[k] = (r > 64'd32767) ? {ENTRY_BITS{1'b1}} : r[ENTRY_BITS-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // registered read port
  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_ROM[addr];
    end
  end

endmodule

// ----- rtl/mwg_shaper.sv -----
// mwg_shaper: turns a phase into a sine, square or triangle sample; holds the output register.
// Depends on mwg_pkg, mwg_out_if; reads the sine table through mwg_sine_rom.
module mwg_shaper #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             adv,
  input  mwg_pkg::stage_ctl_t              s1_ctl,
  input  logic [PHASE_BITS-1:0]            s1_phase,
  input  mwg_pkg::wave_kind_t              kind,
  input  logic [mwg_pkg::AMP_BITS-1:0]     amp,
  output logic [TABLE_BITS-1:0]            rom_addr,
  input  logic [mwg_pkg::ENTRY_BITS-1:0]   rom_data,
  mwg_out_if.source                        wave
);
  import mwg_pkg::*;

  localparam int QB       = PHASE_BITS - 2;          // bits below the quadrant
  localparam int MAG_BITS = PHASE_BITS - 1;          // triangle distance, up to a quarter
  localparam int TRI_BITS = PHASE_BITS + AMP_BITS - 1;
  localparam int SIN_BITS = ENTRY_BITS + AMP_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // stage 2
  stage_ctl_t            s2_ctl;
  logic                  s2_sin_neg;
  logic                  s2_sq_neg;
  logic                  s2_tri_neg;
  logic [MAG_BITS-1:0]   s2_tri_mag;
  // stage 3
  stage_ctl_t            s3_ctl;
  logic                  s3_neg;
  logic [SIN_BITS-1:0]   s3_sin_sum;
  logic [TRI_BITS-1:0]   s3_tri_sum;

  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] idx;
  logic [PHASE_BITS-1:0] tri_v;
  logic [1:0]            tri_q;
  logic [QB-1:0]         tri_lo;
  logic [MAG_BITS-1:0]   tri_mag;
  logic [AMP_BITS-1:0]   mag;
  sample_t               sample_next;

  // the pipeline moves whenever the output register can take a sample
  assign adv = !wave.valid || wave.ready;

  // sine table address, mirrored in the odd quadrants
  assign quad     = s1_phase[PHASE_BITS-1 -: 2];
  assign idx      = s1_phase[QB-1 -: TABLE_BITS];
  assign rom_addr = quad[0] ? ~idx : idx;

  // triangle: distance from the nearest zero crossing of the shifted phase
  assign tri_v   = s1_phase + (PHASE_BITS'(1) << QB);
  assign tri_q   = tri_v[PHASE_BITS-1 -: 2];
  assign tri_lo  = tri_v[QB-1:0];
  assign tri_mag = tri_q[0] ? MAG_BITS'(tri_lo)
                            : (MAG_BITS'(1) << QB) - MAG_BITS'(tri_lo);

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else if (adv) begin
      s2_ctl.valid <= s1_ctl.valid;
      s2_ctl.last  <= s1_ctl.last;
      s2_sin_neg   <= quad[1];
      s2_sq_neg    <= s1_phase[PHASE_BITS-1];
      s2_tri_neg   <= ~(tri_q[1] ^ tri_q[0]);
      s2_tri_mag   <= tri_mag;
    end
  end

  // stage 3: scale by amplitude with rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else if (adv) begin
      s3_ctl.valid <= s2_ctl.valid;
      s3_ctl.last  <= s2_ctl.last;
      s3_sin_sum   <= SIN_BITS'(rom_data) * SIN_BITS'(amp) + (SIN_BITS'(1) << 14);
      s3_tri_sum   <= TRI_BITS'(amp) * TRI_BITS'(s2_tri_mag) + (TRI_BITS'(1) << (QB - 1));
      case (kind)
        WAVE_SQUARE:   s3_neg <= s2_sq_neg;
        WAVE_TRIANGLE: s3_neg <= s2_tri_neg;
        default:       s3_neg <= s2_sin_neg;
      endcase
    end
  end

  // stage 4: select magnitude and apply sign
  always_comb begin
    case (kind)
      WAVE_SQUARE:   mag = amp;
      WAVE_TRIANGLE: mag = s3_tri_sum[QB +: AMP_BITS];
      default:       mag = s3_sin_sum[15 +: AMP_BITS];
    endcase
    sample_next = s3_neg ? -sample_t'(mag) : sample_t'(mag);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wave.valid <= 1'b0;
    end else if (adv) begin
      wave.valid <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wave.sample <= sample_next;
      wave.last   <= s3_ctl.last;
    end
  end

endmodule

// ----- rtl/multi_waveform_generator.sv -----
// multi_waveform_generator: top level of a direct digital synthesis function generator.
// Depends on mwg_pkg, mwg_if, mwg_phase_acc, mwg_sine_rom and mwg_shaper.
// Each accepted request yields one signed sample of a sine, square or triangle wave
// taken at the phase accumulator plus phase_offset; the accumulator then advances by
// phase_step, and restart reloads it with start_phase before the sample is formed.
// The block takes one request per clock and delivers one sample per clock while the
// output is not stalled. Accepting a request loads the phase stage, and the sine table
// read, the amplitude multiply and the output register follow in that order. The only
// loop is the single phase add, so the synchronous table read and the multiply stage
// set the latency, not the rate. A stalled output holds the whole pipeline. Amplitude
// is capped at 2^(SAMPLE_BITS-1)-1. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no sample is
// in flight, as the block itself does not enforce this.
module multi_waveform_generator #(
  parameter int PHASE_BITS  = mwg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = mwg_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = mwg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mwg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mwg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  mwg_in_if.sink                              ctrl,
  mwg_out_if.source                           wave
);
  import mwg_pkg::*;

  localparam int AMP_CAP = (1 << (SAMPLE_BITS - 1)) - 1;

  typedef logic [PHASE_BITS-1:0] phase_t;

  wave_kind_t                wave_kind;
  logic [AMP_BITS-1:0]       amplitude;
  logic [CFG_DATA_BITS-1:0]  phase_step;
  logic [CFG_DATA_BITS-1:0]  phase_offset;
  logic [CFG_DATA_BITS-1:0]  start_phase;

  logic [AMP_BITS-1:0]       amp;
  logic                      adv;
  stage_ctl_t                s1_ctl;
  phase_t                    s1_phase;
  logic [TABLE_BITS-1:0]     rom_addr;
  logic [ENTRY_BITS-1:0]     rom_data;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_kind    <= WAVE_SINE;
      amplitude    <= AMP_BITS'(16384);
      phase_step   <= '0;
      phase_offset <= '0;
      start_phase  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_KIND:    wave_kind    <= wave_kind_t'(cfg_data[1:0]);
        REG_AMPLITUDE:    amplitude    <= cfg_data[AMP_BITS-1:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_PHASE_OFFSET: phase_offset <= cfg_data;
        REG_START_PHASE:  start_phase  <= cfg_data;
        default: ;
      endcase
    end
  end

  // amplitude cap keeps the sample inside its signed range
  assign amp = (32'(amplitude) > 32'(AMP_CAP)) ? AMP_BITS'(AMP_CAP) : amplitude;

  assign ctrl.ready = adv;

  mwg_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_acc (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (ctrl.valid),
    .restart      (ctrl.restart),
    .final_sample (ctrl.final_sample),
    .start_phase  (phase_t'(start_phase)),
    .phase_step   (phase_t'(phase_step)),
    .phase_offset (phase_t'(phase_offset)),
    .s1_ctl       (s1_ctl),
    .s1_phase     (s1_phase)
  );

  mwg_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .data (rom_data)
  );

  mwg_shaper #(
    .PHASE_BITS  (PHASE_BITS),
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_shaper (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1_ctl   (s1_ctl),
    .s1_phase (s1_phase),
    .kind     (wave_kind),
    .amp      (amp),
    .rom_addr (rom_addr),
    .rom_data (rom_data),
    .wave     (wave)
  );

endmodule

// ----- rtl/mwg_checker.sv -----
// mwg_checker: port-level assertions for the waveform generator, bound to the top level.
// Depends on mwg_pkg only through the bound top level's parameters.
module mwg_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          last
);

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a stalled sample stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last))
    else $error("output sample changed while stalled");

  // requests are refused only while a finished sample waits
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused with a free output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // the amplitude cap keeps the most negative code unused
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != MOST_NEG)
    else $error("sample reached the most negative code");

endmodule

bind multi_waveform_generator mwg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mwg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (ctrl.ready),
  .out_valid (wave.valid),
  .out_ready (wave.ready),
  .sample    (wave.sample),
  .last      (wave.last)
);
